// ===== hdl/tick_driven_counter_scheduler_core_assert.svh =====
// Assertion macros for the tick-driven counter scheduler.
`ifndef TICK_DRIVEN_COUNTER_SCHEDULER_CORE_ASSERT_SVH
`define TICK_DRIVEN_COUNTER_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TDCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define TDCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TDCS_ASSERT(lbl, prop, msg)
`define TDCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/tdcs_pkg.sv =====
// Shared types and codes for the tick-driven counter scheduler.
package tdcs_pkg;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDCUR = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_SLAST = 9'b000010000,
        S_RLD   = 9'b000100000,
        S_RLAST = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

endpackage

// ===== hdl/tick_driven_counter_scheduler_core.sv =====
// Tick-driven counter scheduler: per-task counters and priorities, one-comparator scan.
//
// One beat in gives one beat out. A load or a plain tick decrement reads the running
// slot's counter, checks it and passes through the done state to the output register. A
// tick that schedules scans slots 1 to NUM_TASKS-1 through the single read port of the
// counter store, one slot per cycle into one shared comparator; when every counter is
// zero the reload sweep copies the priorities, one slot per cycle, and ranks them through
// the same comparator. The input is not ready while an item is at work.
// Counter and priority stores carry a valid bit per slot cleared by reset, so there is no
// clearing pass; an unwritten slot reads as zero.
`include "tick_driven_counter_scheduler_core_assert.svh"

module tick_driven_counter_scheduler_core
    import tdcs_pkg::*;
#(
    parameter int NUM_TASKS    = 8,
    parameter int COUNTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // task_index[2:0], counter_value[18:3], priority_value[34:19], zero fill [39:35]
    input  logic [39:0] i_s_axis_tdata,
    // command[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // running_task[2:0], switched[3], reloaded[4], none_ready[5], running_counter[21:6],
    // zero fill [23:22]
    output logic [23:0] o_m_axis_tdata
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int CW = COUNTER_BITS;
    localparam logic [TW-1:0] LAST_K  = TW'(NUM_TASKS - 1);
    localparam logic [TW-1:0] FIRST_K = TW'(1);

    // stores
    logic [CW-1:0]        cnt_mem  [NUM_TASKS];
    logic [CW-1:0]        prio_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_cnt_vld;
    logic [NUM_TASKS-1:0] r_prio_vld;
    logic [CW-1:0]        r_cnt_q;
    logic [CW-1:0]        r_prio_q;
    logic                 r_cnt_q_vld;
    logic                 r_prio_q_vld;

    logic          cnt_we;
    logic [TW-1:0] cnt_wa;
    logic [CW-1:0] cnt_wd;
    logic          prio_we;
    logic [TW-1:0] cnt_ra;
    logic [TW-1:0] prio_ra;
    logic [CW-1:0] cnt_rd;
    logic [CW-1:0] prio_rd;

    // sequencer
    t_state        r_state, n_state;
    logic [TW-1:0] r_k, n_k;
    logic [TW-1:0] r_tag;
    logic          r_tag_vld;
    logic          tag_issue;
    logic [TW-1:0] r_cur, n_cur;
    logic [TW-1:0] r_best, n_best;
    logic [CW-1:0] r_best_cnt, n_best_cnt;
    logic          r_cmd, n_cmd;
    logic [CW-1:0] r_res_cnt, n_res_cnt;
    logic          r_sw, n_sw;
    logic          r_rl, n_rl;
    logic          r_nr, n_nr;

    // output register
    logic          r_ovld;
    logic [23:0]   r_odata;
    logic          out_free;

    // input unpacking
    logic          s_accept;
    logic [2:0]    in_idx;
    logic [TW+2:0] in_idx_ext;
    logic [TW-1:0] in_slot;
    logic          in_slot_ok;
    logic [CW+15:0] in_cnt_ext;
    logic [CW+15:0] in_prio_ext;
    logic [CW-1:0] in_cnt;
    logic [CW-1:0] in_prio;

    // shared units
    logic [CW-1:0] cmp_val;
    logic          cmp_take;
    logic [CW-1:0] dec_in;
    logic [CW-1:0] dec_out;

    // output packing
    logic [TW+2:0]  cur_ext;
    logic [CW+15:0] res_ext;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    assign in_idx      = i_s_axis_tdata[2:0];
    assign in_idx_ext  = {{TW{1'b0}}, in_idx};
    assign in_slot     = in_idx_ext[TW-1:0];
    assign in_slot_ok  = (in_idx != 3'd0) && (32'(in_idx) < NUM_TASKS);
    assign in_cnt_ext  = {{CW{1'b0}}, i_s_axis_tdata[18:3]};
    assign in_prio_ext = {{CW{1'b0}}, i_s_axis_tdata[34:19]};
    assign in_cnt      = in_cnt_ext[CW-1:0];
    assign in_prio     = in_prio_ext[CW-1:0];

    assign cnt_rd  = r_cnt_q_vld ? r_cnt_q : '0;
    assign prio_rd = r_prio_q_vld ? r_prio_q : '0;

    // one comparator ranks both the counter scan and the reload sweep
    assign cmp_val  = (r_state == S_RLD || r_state == S_RLAST) ? prio_rd : cnt_rd;
    assign cmp_take = r_tag_vld && (cmp_val != '0) && (cmp_val >= r_best_cnt);

    assign dec_in  = (r_state == S_FIN) ? r_best_cnt : cnt_rd;
    assign dec_out = dec_in - CW'(1);

    assign out_free = !r_ovld || i_m_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_cur      = r_cur;
        n_best     = r_best;
        n_best_cnt = r_best_cnt;
        n_cmd      = r_cmd;
        n_res_cnt  = r_res_cnt;
        n_sw       = r_sw;
        n_rl       = r_rl;
        n_nr       = r_nr;
        cnt_we     = 1'b0;
        cnt_wa     = r_tag;
        cnt_wd     = prio_rd;
        prio_we    = 1'b0;
        cnt_ra     = r_k;
        prio_ra    = r_k;
        tag_issue  = 1'b0;

        if (cmp_take) begin
            n_best     = r_tag;
            n_best_cnt = cmp_val;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_cmd   = i_s_axis_tuser;
                    n_state = S_RDCUR;
                    if (i_s_axis_tuser == CMD_LOAD && in_slot_ok) begin
                        cnt_we  = 1'b1;
                        cnt_wa  = in_slot;
                        cnt_wd  = in_cnt;
                        prio_we = 1'b1;
                    end
                end
            end
            S_RDCUR: begin
                cnt_ra  = r_cur;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_sw = 1'b0;
                n_rl = 1'b0;
                n_nr = 1'b0;
                if (r_cmd == CMD_LOAD) begin
                    n_res_cnt = cnt_rd;
                    n_state   = S_DONE;
                end else if (r_cur != '0 && cnt_rd != '0) begin
                    cnt_we    = 1'b1;
                    cnt_wa    = r_cur;
                    cnt_wd    = dec_out;
                    n_res_cnt = dec_out;
                    n_state   = S_DONE;
                end else begin
                    n_k        = FIRST_K;
                    n_best     = '0;
                    n_best_cnt = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                cnt_ra    = r_k;
                tag_issue = 1'b1;
                if (r_k == LAST_K) begin
                    n_state = S_SLAST;
                end else begin
                    n_k = r_k + FIRST_K;
                end
            end
            S_SLAST: begin
                if (n_best == '0) begin
                    n_k     = FIRST_K;
                    n_state = S_RLD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RLD: begin
                prio_ra   = r_k;
                tag_issue = 1'b1;
                // copy the priority that arrived last cycle into its counter
                if (r_tag_vld) begin
                    cnt_we = 1'b1;
                end
                if (r_k == LAST_K) begin
                    n_state = S_RLAST;
                end else begin
                    n_k = r_k + FIRST_K;
                end
            end
            S_RLAST: begin
                cnt_we  = r_tag_vld;
                n_rl    = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (r_best == '0) begin
                    // all priorities zero: every counter, the running one too, is zero
                    n_nr      = 1'b1;
                    n_res_cnt = '0;
                end else if (r_best != r_cur) begin
                    cnt_we    = 1'b1;
                    cnt_wa    = r_best;
                    cnt_wd    = dec_out;
                    n_cur     = r_best;
                    n_sw      = 1'b1;
                    n_res_cnt = dec_out;
                end else begin
                    n_res_cnt = r_best_cnt;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_tag_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_tag_vld <= tag_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_tag      <= r_k;
        r_best     <= n_best;
        r_best_cnt <= n_best_cnt;
        r_cmd      <= n_cmd;
        r_res_cnt  <= n_res_cnt;
        r_sw       <= n_sw;
        r_rl       <= n_rl;
        r_nr       <= n_nr;
    end

    // counter store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_q     <= cnt_mem[cnt_ra];
        r_cnt_q_vld <= r_cnt_vld[cnt_ra];
    end

    // priority store: written only by loads
    always_ff @(posedge i_clk) begin
        if (prio_we) begin
            prio_mem[in_slot] <= in_prio;
        end
        r_prio_q     <= prio_mem[prio_ra];
        r_prio_q_vld <= r_prio_vld[prio_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld  <= '0;
            r_prio_vld <= '0;
        end else begin
            if (cnt_we) begin
                r_cnt_vld[cnt_wa] <= 1'b1;
            end
            if (prio_we) begin
                r_prio_vld[in_slot] <= 1'b1;
            end
        end
    end

    assign cur_ext = {3'b000, n_cur};
    assign res_ext = {16'h0000, r_res_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_odata <= {2'b00, res_ext[15:0], r_nr, r_rl, r_sw, cur_ext[2:0]};
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;

    `TDCS_ASSERT(a_cur_in_range, 32'(r_cur) < NUM_TASKS, "running slot out of range")
    `TDCS_ASSERT(a_best_cnt_pairs,
        (r_state != S_SLAST && r_state != S_RLAST && r_state != S_FIN)
        || ((r_best != '0) == (r_best_cnt != '0)), "best slot and its count disagree")
    `TDCS_ASSERT(a_flags_consistent,
        !(o_m_axis_tvalid && o_m_axis_tdata[5]) || (o_m_axis_tdata[4] && !o_m_axis_tdata[3]),
        "none_ready without reload or with switch")
    `TDCS_ASSERT_NEXT(a_fin_switch, r_state == S_FIN && r_best != '0 && r_best != r_cur,
        r_cur == $past(r_best), "switch did not take the picked slot")

endmodule
